// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// expr must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

// ===== hdl/hrke_pkg.sv =====
// ----------------------------------------------------------------------------
// hrke_pkg
// Types, constants and code table for the HID report to key event block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hrke_pkg;

   localparam int KEY_SLOTS = 6;
   localparam int NUM_MODS  = 8;
   localparam int MAP_DEPTH = 256;
   localparam int NUM_CAND  = NUM_MODS + 2 * KEY_SLOTS;
   localparam int CAND_W    = $clog2(NUM_CAND);
   localparam int MOD_W     = $clog2(NUM_MODS);

   localparam logic [CAND_W-1:0] CAND_LAST = CAND_W'(NUM_CAND - 1);

   localparam logic MODE_REPORT    = 1'b0;
   localparam logic MODE_MAP_WRITE = 1'b1;

   localparam logic [7:0] CODE_CONTROL = 8'h36;
   localparam logic [7:0] CODE_SHIFT   = 8'h38;
   localparam logic [7:0] CODE_OPTION  = 8'h3A;
   localparam logic [7:0] CODE_COMMAND = 8'h37;
   localparam logic [7:0] CODE_DROP    = 8'hFF;

   typedef logic [7:0] key_type;
   typedef key_type [KEY_SLOTS-1:0] keys_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_DRAIN
   } seq_state_type;

   typedef struct packed {
      logic rel_act;
      logic prs_act;
   } lane_flags_type;

   typedef struct packed {
      logic [NUM_CAND-1:0]    act;
      logic [NUM_CAND-1:0]    rel;
      logic [NUM_CAND-1:0]    is_key;
      key_type [NUM_CAND-1:0] value;
   } cand_type;

   typedef struct packed {
      logic    en;
      key_type index;
      key_type code;
   } map_wr_type;

   // left and right modifiers share a code
   function automatic key_type mod_code(input logic [MOD_W-1:0] bit_idx);
      key_type code;
      case (bit_idx[1:0])
         2'd0:    code = CODE_CONTROL;
         2'd1:    code = CODE_SHIFT;
         2'd2:    code = CODE_OPTION;
         default: code = CODE_COMMAND;
      endcase
      return code;
   endfunction

endpackage

// ===== hdl/hrke_req_if.sv =====
// ----------------------------------------------------------------------------
// hrke_req_if
// Request channel: keyboard report or map write beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hrke_req_if;
   import hrke_pkg::*;

   logic    valid;
   logic    ready;
   logic    mode;
   key_type modifier_bits;
   key_type key_slot_0;
   key_type key_slot_1;
   key_type key_slot_2;
   key_type key_slot_3;
   key_type key_slot_4;
   key_type key_slot_5;
   key_type map_index;
   key_type map_code;

   modport source (
      output valid, mode, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
             key_slot_3, key_slot_4, key_slot_5, map_index, map_code,
      input  ready
   );

   modport sink (
      input  valid, mode, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
             key_slot_3, key_slot_4, key_slot_5, map_index, map_code,
      output ready
   );

endinterface

// ===== hdl/hrke_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hrke_rsp_if
// Response channel: one key event per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hrke_rsp_if;
   import hrke_pkg::*;

   logic    valid;
   logic    ready;
   logic    event_release;
   key_type target_code;
   logic    last_of_run;

   modport source (
      output valid, event_release, target_code, last_of_run,
      input  ready
   );

   modport sink (
      input  valid, event_release, target_code, last_of_run,
      output ready
   );

endinterface

// ===== hdl/hrke_lane.sv =====
// ----------------------------------------------------------------------------
// hrke_lane
// One slot lane: flags a non-zero old key absent from the new report as
// released, a non-zero new key absent from the old report as pressed.
`timescale 1ns / 1ps

module hrke_lane (
   input  hrke_pkg::key_type        old_key,
   input  hrke_pkg::key_type        new_key,
   input  hrke_pkg::keys_type       old_keys,
   input  hrke_pkg::keys_type       new_keys,
   output hrke_pkg::lane_flags_type flags
);
   import hrke_pkg::*;

   logic old_seen;
   logic new_seen;

   always_comb begin
      old_seen = 1'b0;
      new_seen = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
         if (new_keys[j] == old_key) old_seen = 1'b1;
         if (old_keys[j] == new_key) new_seen = 1'b1;
      end
      flags.rel_act = (old_key != '0) && !old_seen;
      flags.prs_act = (new_key != '0) && !new_seen;
   end

endmodule

// ===== hdl/hrke_seq.sv =====
// ----------------------------------------------------------------------------
// hrke_seq
// Merge sequencer: walks the candidates, translates keys, emits events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrke_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  hrke_pkg::cand_type   cand,
   input  hrke_pkg::map_wr_type map_wr,
   output logic                 idle,
   hrke_rsp_if.source           rsp
);
   import hrke_pkg::*;
   `include "assert_macros.svh"

   key_type map_mem [MAP_DEPTH];

   seq_state_type     state_ff, state_in;
   logic [CAND_W-1:0] idx_ff, idx_in;
   logic              b_valid_ff, b_valid_in;
   logic              b_rel_ff, b_rel_in;
   logic              b_key_ff, b_key_in;
   key_type           b_val_ff, b_val_in;
   key_type           rd_ff;
   logic              pend_valid_ff, pend_valid_in;
   logic              pend_rel_ff, pend_rel_in;
   key_type           pend_code_ff, pend_code_in;
   logic              out_valid_ff, out_valid_in;
   logic              out_rel_ff, out_rel_in;
   key_type           out_code_ff, out_code_in;
   logic              out_last_ff, out_last_in;

   logic    a_fire;
   logic    ev_valid;
   key_type ev_code;
   logic    out_free;
   logic    stall;
   logic    push_last;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      b_valid_in    = b_valid_ff;
      b_rel_in      = b_rel_ff;
      b_key_in      = b_key_ff;
      b_val_in      = b_val_ff;
      pend_valid_in = pend_valid_ff;
      pend_rel_in   = pend_rel_ff;
      pend_code_in  = pend_code_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_rel_in    = out_rel_ff;
      out_code_in   = out_code_ff;
      out_last_in   = out_last_ff;
      a_fire        = 1'b0;
      push_last     = 1'b0;

      ev_valid = b_valid_ff && !(b_key_ff && (rd_ff == CODE_DROP));
      ev_code  = b_key_ff ? rd_ff : b_val_ff;
      out_free = !out_valid_ff || rsp.ready;
      stall    = ev_valid && pend_valid_ff && !out_free;

      // one event is held back until the next one shows whether it is last
      if (!stall) begin
         b_valid_in = 1'b0;
         if (ev_valid) begin
            if (pend_valid_ff) begin
               out_valid_in = 1'b1;
               out_rel_in   = pend_rel_ff;
               out_code_in  = pend_code_ff;
               out_last_in  = 1'b0;
            end
            pend_valid_in = 1'b1;
            pend_rel_in   = b_rel_ff;
            pend_code_in  = ev_code;
         end
      end

      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               state_in = SEQ_SCAN;
               idx_in   = '0;
            end
         end
         SEQ_SCAN: begin
            if (!stall) begin
               a_fire     = 1'b1;
               b_valid_in = cand.act[idx_ff];
               b_rel_in   = cand.rel[idx_ff];
               b_key_in   = cand.is_key[idx_ff];
               b_val_in   = cand.value[idx_ff];
               idx_in     = CAND_W'(idx_ff + 1'b1);
               if (idx_ff == CAND_LAST) state_in = SEQ_DRAIN;
            end
         end
         SEQ_DRAIN: begin
            if (!b_valid_ff) begin
               if (!pend_valid_ff) begin
                  state_in = SEQ_IDLE;
               end else if (out_free) begin
                  out_valid_in  = 1'b1;
                  out_rel_in    = pend_rel_ff;
                  out_code_in   = pend_code_ff;
                  out_last_in   = 1'b1;
                  pend_valid_in = 1'b0;
                  push_last     = 1'b1;
                  state_in      = SEQ_IDLE;
               end
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEQ_IDLE;
         idx_ff        <= '0;
         b_valid_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         b_valid_ff    <= b_valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_rel_ff     <= b_rel_in;
      b_key_ff     <= b_key_in;
      b_val_ff     <= b_val_in;
      pend_rel_ff  <= pend_rel_in;
      pend_code_ff <= pend_code_in;
      out_rel_ff   <= out_rel_in;
      out_code_ff  <= out_code_in;
      out_last_ff  <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (map_wr.en) map_mem[map_wr.index] <= map_wr.code;
      if (a_fire) rd_ff <= map_mem[cand.value[idx_ff]];
   end

   assign idle              = (state_ff == SEQ_IDLE);
   assign rsp.valid         = out_valid_ff;
   assign rsp.event_release = out_rel_ff;
   assign rsp.target_code   = out_code_ff;
   assign rsp.last_of_run   = out_last_ff;

   `ASSERT_NEVER(a_idle_no_pend, (state_ff == SEQ_IDLE) && pend_valid_ff, "held event in idle")
   `ASSERT_NEVER(a_idle_b_empty, (state_ff == SEQ_IDLE) && b_valid_ff, "lookup busy in idle")
   `ASSERT_CLK(a_last_ends_run, push_last |=> (state_ff == SEQ_IDLE), "last beat before run end")
   `ASSERT_NEVER(a_start_busy, start && (state_ff != SEQ_IDLE), "report started while busy")

endmodule

// ===== hdl/hid_report_to_key_events.sv =====
// ----------------------------------------------------------------------------
// hid_report_to_key_events
// Boot keyboard report to key down/up events through a usage map.
//
//   channel  dir  beat
//   req_bus  in   report (mode 0) or map entry write (mode 1)
//   rsp_bus  out  one key event, last_of_run on the final one of a report
//
// A map write gives no beat.
// A report is run by the sequencer, which steps one candidate per cycle
// through the map read unless stalled; req_ready is low meanwhile.
// A stalled rsp_bus holds the sequencer only when two events are queued.
// Reset clears the held report; map entries stay undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hid_report_to_key_events (
   input  logic       clock,
   input  logic       reset,
   hrke_req_if.sink   req_bus,
   hrke_rsp_if.source rsp_bus
);
   import hrke_pkg::*;

   key_type        prev_mods_ff;
   keys_type       prev_keys_ff;
   cand_type       cand_ff, cand_in;
   keys_type       new_keys;
   lane_flags_type lane_flags [KEY_SLOTS];
   map_wr_type     map_wr;
   logic           accept;
   logic           report_accept;
   logic           seq_idle;

   assign new_keys = {req_bus.key_slot_5, req_bus.key_slot_4, req_bus.key_slot_3,
                      req_bus.key_slot_2, req_bus.key_slot_1, req_bus.key_slot_0};

   assign req_bus.ready = seq_idle;
   assign accept        = req_bus.valid && req_bus.ready;
   assign report_accept = accept && (req_bus.mode == MODE_REPORT);

   assign map_wr.en    = accept && (req_bus.mode == MODE_MAP_WRITE);
   assign map_wr.index = req_bus.map_index;
   assign map_wr.code  = req_bus.map_code;

   for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_lane
      hrke_lane u_lane (
         .old_key  (prev_keys_ff[i]),
         .new_key  (new_keys[i]),
         .old_keys (prev_keys_ff),
         .new_keys (new_keys),
         .flags    (lane_flags[i])
      );
   end

   // candidate order: modifiers, releases by old slot, presses by new slot
   always_comb begin
      for (int m = 0; m < NUM_MODS; m++) begin
         cand_in.act[m]    = prev_mods_ff[m] ^ req_bus.modifier_bits[m];
         cand_in.rel[m]    = !req_bus.modifier_bits[m];
         cand_in.is_key[m] = 1'b0;
         cand_in.value[m]  = mod_code(MOD_W'(m));
      end
      for (int i = 0; i < KEY_SLOTS; i++) begin
         cand_in.act[NUM_MODS + i]                = lane_flags[i].rel_act;
         cand_in.rel[NUM_MODS + i]                = 1'b1;
         cand_in.is_key[NUM_MODS + i]             = 1'b1;
         cand_in.value[NUM_MODS + i]              = prev_keys_ff[i];
         cand_in.act[NUM_MODS + KEY_SLOTS + i]    = lane_flags[i].prs_act;
         cand_in.rel[NUM_MODS + KEY_SLOTS + i]    = 1'b0;
         cand_in.is_key[NUM_MODS + KEY_SLOTS + i] = 1'b1;
         cand_in.value[NUM_MODS + KEY_SLOTS + i]  = new_keys[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_mods_ff <= '0;
         prev_keys_ff <= '0;
      end else if (report_accept) begin
         prev_mods_ff <= req_bus.modifier_bits;
         prev_keys_ff <= new_keys;
      end
   end

   always_ff @(posedge clock) begin
      if (report_accept) cand_ff <= cand_in;
   end

   hrke_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (report_accept),
      .cand   (cand_ff),
      .map_wr (map_wr),
      .idle   (seq_idle),
      .rsp    (rsp_bus)
   );

endmodule
